### src/rtlp_pkg.sv
// shared types and codes for the longest-prefix route table
package rtlp_pkg;

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_DEL  = 2'd1;
  localparam logic [1:0] MODE_LOOK = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  localparam logic [31:0] TOP_BIT = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] dest;
    logic [31:0] gateway;
    logic [31:0] mask;
    logic [3:0]  iface_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] hit_gateway;
    logic [31:0] hit_mask;
    logic [31:0] hit_dest;
    logic [3:0]  hit_iface;
    logic [5:0]  prefix_length;
    logic [4:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] gateway;
    logic [31:0] mask;
    logic [3:0]  iface;
  } entry_t;

  // operation token that walks the cell row
  typedef struct packed {
    logic       valid;
    req_t       req;
    logic       found;
    logic [5:0] best_len;
    entry_t     best;
  } token_t;

endpackage

### src/rtlp_cell.sv
// one route entry cell: holds a route and updates the passing token
module rtlp_cell #(
  parameter int MAX_ENTRIES = 16,
  parameter int INDEX       = 0,
  localparam int CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CNT_W-1:0]    count,
  input  rtlp_pkg::token_t    tok_in,
  input  rtlp_pkg::entry_t    succ,
  output rtlp_pkg::token_t    tok_out,
  output rtlp_pkg::entry_t    ent
);
  import rtlp_pkg::*;

  // leading ones in a halving search
  function automatic logic [5:0] lead_ones(input logic [31:0] m);
    logic [31:0] x;
    logic [5:0]  n;
    x = m;
    n = 6'd0;
    if (x[31:16] == 16'hFFFF) begin
      n = n + 6'd16;
      x = x << 16;
    end
    if (x[31:24] == 8'hFF) begin
      n = n + 6'd8;
      x = x << 8;
    end
    if (x[31:28] == 4'hF) begin
      n = n + 6'd4;
      x = x << 4;
    end
    if (x[31:30] == 2'b11) begin
      n = n + 6'd2;
      x = x << 2;
    end
    if (x[31]) begin
      n = n + 6'd1;
      x = x << 1;
    end
    if ((x & TOP_BIT) != 32'd0) begin
      n = n + 6'd1;
    end
    return n;
  endfunction

  token_t      tok_next;
  entry_t      ent_next;
  logic        ent_we;
  logic        occupied;
  logic        del_here;
  logic        look_hit;
  logic [5:0]  len;

  assign occupied = CNT_W'(INDEX) < count;
  assign len      = lead_ones(ent.mask);
  assign del_here = occupied && !tok_in.found && (ent.dest == tok_in.req.dest);
  assign look_hit = occupied &&
                    ((tok_in.req.dest & ent.mask) == (ent.dest & ent.mask));

  always_comb begin
    tok_next       = tok_in;
    tok_next.valid = 1'b1;
    ent_next       = succ;
    ent_we         = 1'b0;
    case (tok_in.req.mode)
      MODE_ADD: begin
        if (CNT_W'(INDEX) == count) begin
          ent_we           = tok_in.valid;
          ent_next.dest    = tok_in.req.dest;
          ent_next.gateway = tok_in.req.gateway;
          ent_next.mask    = tok_in.req.mask;
          ent_next.iface   = tok_in.req.iface_id;
        end
      end
      MODE_DEL: begin
        // from the deleted slot on, each cell takes its successor's route
        if (occupied && (tok_in.found || del_here)) begin
          ent_we = tok_in.valid;
        end
        tok_next.found = tok_in.found | del_here;
      end
      MODE_LOOK: begin
        if (look_hit && (!tok_in.found || len > tok_in.best_len)) begin
          tok_next.found    = 1'b1;
          tok_next.best_len = len;
          tok_next.best     = ent;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (tok_in.valid) begin
      tok_out <= tok_next;
    end else begin
      tok_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent <= ent_next;
    end
  end

endmodule

### src/route_table_longest_prefix.sv
// top level: IPv4 route table with longest prefix lookup over a row of cells
// a request transfer sends a token through the registered cell row, then the finish step
// loads the response register, which can stall while an earlier response is not yet taken;
// a new request is accepted only once the finish step is done and the control is idle
// a new request is taken while the previous response still waits
// reset clears the route count, the control state and rsp_valid; route cells keep contents
module route_table_longest_prefix #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  rtlp_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rtlp_pkg::rsp_t   rsp
);
  import rtlp_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  token_t             tok [0:MAX_ENTRIES];
  entry_t             ent [0:MAX_ENTRIES-1];
  logic [MAX_ENTRIES-1:0] tok_valids;
  token_t             fin;
  rsp_t               rsp_next;
  logic               rsp_load;
  logic               req_xfer;

  assign req_ready = (state == S_IDLE);
  assign req_xfer  = req_valid && req_ready;

  // token enters cell 0 straight from the request transfer
  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = req_xfer;
    tok[0].req      = req;
  end

  // row of route cells; the last cell has no successor to pull from
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    entry_t succ;
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign succ = ent[i];
    end else begin : g_mid
      assign succ = ent[i+1];
    end
    rtlp_cell #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .INDEX      (i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .count  (count),
      .tok_in (tok[i]),
      .succ   (succ),
      .tok_out(tok[i+1]),
      .ent    (ent[i])
    );
    assign tok_valids[i] = tok[i+1].valid;
  end

  // the last cell's token holds its payload after the walk completes
  assign fin = tok[MAX_ENTRIES];

  // response and new count from the finished token
  always_comb begin
    rsp_next   = '0;
    count_next = count;
    rsp_next.status = ST_MISS;
    case (fin.req.mode)
      MODE_ADD: begin
        if (count >= CNT_W'(MAX_ENTRIES)) begin
          rsp_next.status = ST_FULL;
        end else begin
          rsp_next.status = ST_OK;
          count_next      = count + CNT_W'(1);
        end
      end
      MODE_DEL: begin
        if (fin.found) begin
          rsp_next.status = ST_OK;
          count_next      = count - CNT_W'(1);
        end
      end
      MODE_LOOK: begin
        if (fin.found) begin
          rsp_next.status        = ST_OK;
          rsp_next.hit_gateway   = fin.best.gateway;
          rsp_next.hit_mask      = fin.best.mask;
          rsp_next.hit_dest      = fin.best.dest;
          rsp_next.hit_iface     = fin.best.iface;
          rsp_next.prefix_length = fin.best_len;
        end
      end
      default: begin
      end
    endcase
    // count wider than the field for large tables; keep low bits
    rsp_next.entry_count = 5'(count_next);
  end

  // finish only once the response register is free or being drained
  assign rsp_load = (state == S_FINISH) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_xfer) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (fin.valid) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        count <= count_next;
      end
    end
  end

  // output register parts the request side from the response side
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // at most one token in the row
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valids))
    else $error("more than one token in the cell row");

  // count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("route count beyond table size");

  // the walk only ends while scanning
  a_fin_in_scan: assert property (@(posedge clk) disable iff (rst)
    fin.valid |-> state == S_SCAN)
    else $error("token left the row outside a scan");

  // a full answer only when the table is full
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> count == CNT_W'(MAX_ENTRIES))
    else $error("table full reported with free slots");

  // a response appears only after a finish step
  a_rsp_after_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_FINISH)
    else $error("response without finished operation");

endmodule
